[rtl/core/assert_macros.svh]
// Assertion macros used by the xxtea64 block cipher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: property violated");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[rtl/core/x64_pkg.sv]
// Shared constants, types and the round-count table of the xxtea64 block.
`default_nettype none
package x64_pkg;

    localparam int MAX_WORDS = 16;
    localparam int IDX_W     = $clog2(MAX_WORDS);
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int WORD_W    = 64;
    localparam int ROUND_W   = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR   = 3'd4;

    localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

    typedef logic [WORD_W-1:0]        t_word;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [ROUND_W-1:0]       t_rounds;
    typedef logic [31+ROUND_W:0]      t_sum_init;
    typedef logic [3:0][WORD_W-1:0]   t_key_set;

    // Datapath controls driven by the sequencer.
    typedef struct packed {
        logic        wr_en;
        logic        wr_src_in;
        t_idx        wr_addr;
        logic        rd_a_en;
        t_idx        rd_a_addr;
        logic        rd_b_en;
        t_idx        rd_b_addr;
        logic        nb_load;
        logic        mix_en;
        logic        upd_en;
        logic        decrypt;
        logic [1:0]  key_sel;
        t_word       sum;
    } t_dp_ctrl;

    // Output register load request.
    typedef struct packed {
        logic load;
        logic eob;
        logic too_long;
    } t_emit;

    // Rounds for an n-word block: 6 + 52 / n.
    function automatic t_rounds rounds_for(t_cnt n);
        t_rounds r;
        unique case (n) inside
            2:       r = t_rounds'(32);
            3:       r = t_rounds'(23);
            4:       r = t_rounds'(19);
            5:       r = t_rounds'(16);
            6:       r = t_rounds'(14);
            7:       r = t_rounds'(13);
            8:       r = t_rounds'(12);
            [9:10]:  r = t_rounds'(11);
            [11:13]: r = t_rounds'(10);
            [14:17]: r = t_rounds'(9);
            [18:26]: r = t_rounds'(8);
            [27:52]: r = t_rounds'(7);
            default: r = t_rounds'(6);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/xxtea64_block_cipher.sv]
// Top level of the xxtea64 block cipher: configuration, output register, checks.
//
// Usage: words of one block enter on the input channel (i_in_valid / o_in_stall),
// one per accepted item, in index order; i_last_word marks the final word. Up to
// MAX_WORDS (16) words are kept; later words are dropped and every output word of
// that block carries o_too_long. Keys and direction are written through the
// i_cfg_* port (index 0..3 keys, 4 direction) between blocks.
// After the last word the block is encrypted or decrypted in place in the word
// memory: each mixing step reads two words, mixes them and writes back, and an
// n-word block with r = 6 + 52/n rounds takes n*r mixing steps; then each word
// is read and loaded into the output register, waiting while that register is
// held. A one-word block skips processing. Input stays stalled from the last
// word until the final word of the block has been loaded into the output
// register; loading the next block overlaps the wait for that last word.
// The output register holds its item while i_out_stall is high, and the emitter
// waits for it. Reset clears the keys, direction, counters and the output valid.
`default_nettype none
`include "assert_macros.svh"
module xxtea64_block_cipher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [63:0]                       i_word_in,
    input  logic                              i_last_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [63:0]                       o_word_out,
    output logic                              o_end_of_block,
    output logic                              o_too_long,
    input  logic                              i_cfg_wr_en,
    input  logic [x64_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [63:0]                       i_cfg_data
);
    import x64_pkg::*;

    t_key_set  r_keys;
    logic      r_dir;
    logic      r_out_valid;
    t_word     r_word_out;
    logic      r_eob;
    logic      r_too_long;

    t_dp_ctrl  dp_ctrl;
    t_emit     emit;
    t_word     rd_data;
    logic      out_accept;
    logic      out_free;
    logic      in_accept;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = r_out_valid && !i_out_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
            r_dir  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_KEY_0: r_keys[0] <= i_cfg_data;
                CFG_KEY_1: r_keys[1] <= i_cfg_data;
                CFG_KEY_2: r_keys[2] <= i_cfg_data;
                CFG_KEY_3: r_keys[3] <= i_cfg_data;
                CFG_DIR:   r_dir     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    x64_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_word (i_last_word),
        .i_decrypt   (r_dir),
        .i_out_free  (out_free),
        .o_in_stall  (o_in_stall),
        .o_dp        (dp_ctrl),
        .o_emit      (emit)
    );

    x64_store u_store (
        .i_clk     (i_clk),
        .i_ctrl    (dp_ctrl),
        .i_word_in (i_word_in),
        .i_keys    (r_keys),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.load) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.load) begin
            r_word_out <= rd_data;
            r_eob      <= emit.eob;
            r_too_long <= emit.too_long;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_word_out     = r_word_out;
    assign o_end_of_block = r_eob;
    assign o_too_long     = r_too_long;

    `ASSERT_PROP(a_stall_after_last, i_clk, i_rst_n, in_accept && i_last_word |=> o_in_stall)
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, emit.load && r_out_valid)
    `ASSERT_PROP(a_gap_after_eob, i_clk, i_rst_n, out_accept && r_eob |=> !r_out_valid)

endmodule
`default_nettype wire

[rtl/core/x64_store.sv]
// Block word memory with two read ports, the mixing stage and the update stage.
`default_nettype none
module x64_store (
    input  logic               i_clk,
    input  x64_pkg::t_dp_ctrl  i_ctrl,
    input  x64_pkg::t_word     i_word_in,
    input  x64_pkg::t_key_set  i_keys,
    output x64_pkg::t_word     o_rd_data
);
    import x64_pkg::*;

    t_word r_mem [MAX_WORDS];
    t_word r_rd_a;
    t_word r_rd_b;
    t_word r_mix;
    t_word r_nb;

    t_word mix_y;
    t_word mix_z;
    t_word mix_key;
    t_word n_mix;
    t_word n_result;
    t_word wr_data;

    // Encrypt mixes (y = next word, z = neighbour); decrypt swaps the roles.
    always_comb begin
        mix_y    = i_ctrl.decrypt ? r_nb : r_rd_b;
        mix_z    = i_ctrl.decrypt ? r_rd_b : r_nb;
        mix_key  = i_keys[i_ctrl.key_sel];
        n_mix    = (((mix_z >> 5) ^ (mix_y << 2)) + ((mix_y >> 3) ^ (mix_z << 4)))
                 ^ ((i_ctrl.sum ^ mix_y) + (mix_key ^ mix_z));
        n_result = i_ctrl.decrypt ? (r_rd_a - r_mix) : (r_rd_a + r_mix);
        wr_data  = i_ctrl.wr_src_in ? i_word_in : n_result;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.wr_addr] <= wr_data;
        end
        if (i_ctrl.rd_a_en) begin
            r_rd_a <= r_mem[i_ctrl.rd_a_addr];
        end
        if (i_ctrl.rd_b_en) begin
            r_rd_b <= r_mem[i_ctrl.rd_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mix_en) begin
            r_mix <= n_mix;
        end
        if (i_ctrl.nb_load) begin
            r_nb <= r_rd_a;
        end else if (i_ctrl.upd_en) begin
            r_nb <= n_result;
        end
    end

    assign o_rd_data = r_rd_a;

endmodule
`default_nettype wire

[rtl/core/x64_ctrl.sv]
// Sequencer: word loading, round and step counting, round sum and emission.
`default_nettype none
module x64_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_last_word,
    input  logic               i_decrypt,
    input  logic               i_out_free,
    output logic               o_in_stall,
    output x64_pkg::t_dp_ctrl  o_dp,
    output x64_pkg::t_emit     o_emit
);
    import x64_pkg::*;

    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_SETUP   = 4'd1;
    localparam logic [3:0] S_NB_RD   = 4'd2;
    localparam logic [3:0] S_NB_LD   = 4'd3;
    localparam logic [3:0] S_RD      = 4'd4;
    localparam logic [3:0] S_MIX     = 4'd5;
    localparam logic [3:0] S_UPD     = 4'd6;
    localparam logic [3:0] S_EMIT_RD = 4'd7;
    localparam logic [3:0] S_EMIT_LD = 4'd8;

    logic [3:0] r_state, n_state;
    t_cnt       r_cnt, n_cnt;
    logic       r_ovf, n_ovf;
    t_cnt       r_n, n_n;
    logic       r_too_long, n_too_long;
    logic       r_dec, n_dec;
    t_word      r_sum, n_sum;
    t_rounds    r_rounds, n_rounds;
    t_idx       r_p, n_p;

    logic       in_accept;
    logic       have_room;
    logic       round_end;
    t_idx       top_idx;
    t_sum_init  init_prod;

    assign in_accept  = i_in_valid && (r_state == S_LOAD);
    assign o_in_stall = (r_state != S_LOAD);
    assign have_room  = (r_cnt < t_cnt'(MAX_WORDS));
    assign top_idx    = IDX_W'(r_n - t_cnt'(1));
    assign init_prod  = t_sum_init'(TEA_DELTA) * t_sum_init'(rounds_for(r_n));
    assign round_end  = r_dec ? (r_p == '0) : (r_p == top_idx);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        n_n        = r_n;
        n_too_long = r_too_long;
        n_dec      = r_dec;
        n_sum      = r_sum;
        n_rounds   = r_rounds;
        n_p        = r_p;

        o_dp         = '0;
        o_dp.decrypt = r_dec;
        o_dp.sum     = r_sum;
        o_dp.key_sel = 2'(r_p) ^ r_sum[3:2];
        o_emit          = '0;
        o_emit.too_long = r_too_long;
        o_emit.eob      = (r_p == top_idx);

        unique case (r_state)
            S_LOAD: begin
                if (in_accept) begin
                    if (have_room) begin
                        o_dp.wr_en     = 1'b1;
                        o_dp.wr_src_in = 1'b1;
                        o_dp.wr_addr   = IDX_W'(r_cnt);
                        n_cnt          = r_cnt + t_cnt'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_word) begin
                        n_n        = have_room ? (r_cnt + t_cnt'(1)) : r_cnt;
                        n_too_long = r_ovf || !have_room;
                        n_cnt      = '0;
                        n_ovf      = 1'b0;
                        n_state    = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_dec = i_decrypt;
                n_p   = '0;
                if (r_n < t_cnt'(2)) begin
                    // single word: pass through
                    n_state = S_EMIT_RD;
                end else begin
                    n_rounds = rounds_for(r_n);
                    n_sum    = i_decrypt ? WORD_W'(init_prod) : WORD_W'(TEA_DELTA);
                    n_p      = i_decrypt ? top_idx : '0;
                    n_state  = S_NB_RD;
                end
            end
            S_NB_RD: begin
                o_dp.rd_a_en   = 1'b1;
                o_dp.rd_a_addr = r_dec ? '0 : top_idx;
                n_state        = S_NB_LD;
            end
            S_NB_LD: begin
                o_dp.nb_load = 1'b1;
                n_state      = S_RD;
            end
            S_RD: begin
                o_dp.rd_a_en   = 1'b1;
                o_dp.rd_a_addr = r_p;
                o_dp.rd_b_en   = 1'b1;
                if (r_dec) begin
                    o_dp.rd_b_addr = (r_p == '0) ? top_idx : (r_p - t_idx'(1));
                end else begin
                    o_dp.rd_b_addr = (r_p == top_idx) ? '0 : (r_p + t_idx'(1));
                end
                n_state = S_MIX;
            end
            S_MIX: begin
                o_dp.mix_en = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                // write back; the next read is issued after this edge
                o_dp.upd_en  = 1'b1;
                o_dp.wr_en   = 1'b1;
                o_dp.wr_addr = r_p;
                n_state      = S_RD;
                if (round_end) begin
                    n_p      = r_dec ? top_idx : '0;
                    n_sum    = r_dec ? (r_sum - WORD_W'(TEA_DELTA))
                                     : (r_sum + WORD_W'(TEA_DELTA));
                    n_rounds = r_rounds - t_rounds'(1);
                    if (r_rounds == t_rounds'(1)) begin
                        n_p     = '0;
                        n_state = S_EMIT_RD;
                    end
                end else begin
                    n_p = r_dec ? (r_p - t_idx'(1)) : (r_p + t_idx'(1));
                end
            end
            S_EMIT_RD: begin
                // hold until the output register frees up
                if (i_out_free) begin
                    o_dp.rd_a_en   = 1'b1;
                    o_dp.rd_a_addr = r_p;
                    n_state        = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                o_emit.load = 1'b1;
                if (r_p == top_idx) begin
                    n_state = S_LOAD;
                end else begin
                    n_p     = r_p + t_idx'(1);
                    n_state = S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
            r_n        <= '0;
            r_too_long <= 1'b0;
            r_dec      <= 1'b0;
            r_sum      <= '0;
            r_rounds   <= '0;
            r_p        <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_ovf      <= n_ovf;
            r_n        <= n_n;
            r_too_long <= n_too_long;
            r_dec      <= n_dec;
            r_sum      <= n_sum;
            r_rounds   <= n_rounds;
            r_p        <= n_p;
        end
    end

endmodule
`default_nettype wire
